/* rtl/polymer_chain_shape_stats_assert.svh */
// ----------------------------------------------------------------------------
// Polymer chain shape statistics: assertion macros
// Shared wrappers for the concurrent checks of the shape statistics block.
// ----------------------------------------------------------------------------
`ifndef POLYMER_CHAIN_SHAPE_STATS_ASSERT_SVH
`define POLYMER_CHAIN_SHAPE_STATS_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define PCSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define PCSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pcss_pkg.sv */
// ----------------------------------------------------------------------------
// Polymer chain shape statistics: package
// Word types, state encoding and constants of the shape statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcss_pkg;

    localparam int unsigned MAX_BEADS_DEF = 1024;
    localparam int unsigned LEN_W         = 11;
    localparam int unsigned E_W           = 50;
    localparam int unsigned SQRT_W        = 64;
    localparam int unsigned SQRT_STEPS    = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd2;
    localparam logic [2:0]       STEP_LAST = 3'd6;
    localparam logic [1:0]       AXIS_TOTAL = 2'd3;
    localparam logic [23:0]      MAX24 = 24'hFFFFFF;
    localparam logic [35:0]      MAX36 = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic signed [23:0] x_pos;
        logic signed [23:0] y_pos;
        logic signed [23:0] z_pos;
    } bead_t;

    typedef struct packed {
        logic [1:0]  axis;
        logic [23:0] bond_rms;
        logic [35:0] gyration_sq;
        logic [35:0] end_to_end_sq;
        logic [23:0] shape_ratio;
        logic        last;
    } shape_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BEAD,
        ST_NN,
        ST_NNSET,
        ST_GSET,
        ST_GMUL1,
        ST_GMUL2,
        ST_GSUB,
        ST_GDIV,
        ST_BDIV,
        ST_SQRT,
        ST_RMUL,
        ST_RDIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/polymer_chain_shape_stats.sv */
// ----------------------------------------------------------------------------
// Polymer chain shape statistics
// Accumulates the beads of one chain and gives the rms bond length, squared
// radius of gyration and squared end-to-end distance per axis and in total.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Word
//  in       in_valid  in_ready  in_data    one bead (bead_t)
//  out      out_valid out_ready out_data   one result (shape_t)
//  cfg      cfg_valid cfg_ready cfg_data   beads per chain
//
//  A bead is taken in and then squared, coordinate and step per axis, on the
//  shared 25 x 25 bit multiplier. The chain end runs on one shared adder,
//  per axis and then for the total (one division fewer when the gyration
//  total is zero). Reset is asynchronous and active low. A waiting result
//  holds the sequencer at its hand-over state, and no bead or length word is
//  taken until the total word has been handed over.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polymer_chain_shape_stats_assert.svh"

module polymer_chain_shape_stats
    import pcss_pkg::*;
#(
    parameter int unsigned MAX_BEADS = MAX_BEADS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bead_t            in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output shape_t                out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [LEN_W-1:0] cfg_data
);

    localparam int unsigned CNT_W  = $clog2(MAX_BEADS + 1);
    localparam int unsigned CSUM_W = 24 + CNT_W;
    localparam int unsigned SSUM_W = 48 + CNT_W;
    localparam int unsigned BSUM_W = 49 + CNT_W;
    localparam int unsigned BTOT_W = BSUM_W + 2;
    localparam int unsigned NN_W   = 2 * CNT_W;
    localparam int unsigned UW     = 2 * CNT_W + 72;
    localparam int unsigned IT_W   = $clog2(UW + 1);

    state_t state_reg, state_next;
    logic [2:0]             step_reg;
    logic [1:0]             ax_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [LEN_W-1:0]       cfg_len_reg;
    logic                   out_valid_reg;
    shape_t                 out_data_reg;
    bead_t                  in_word_reg;

    logic signed [23:0]       first_reg [3];
    logic signed [23:0]       prev_reg  [3];
    logic signed [CSUM_W-1:0] csum_reg  [3];
    logic [SSUM_W-1:0]        ssum_reg  [3];
    logic [BSUM_W-1:0]        bsum_reg  [3];

    logic [49:0]      prod_reg;
    logic [NN_W-1:0]  nn_reg;
    logic [UW-1:0]    ua_reg, ub_reg, uq_reg, ud_reg, t1_reg, gtot_reg;
    logic [IT_W-1:0]  it_reg;
    logic [E_W-1:0]   etot_reg, e_reg;
    logic [BTOT_W-1:0] btot_reg;
    logic [35:0]      gy_reg;
    logic [23:0]      bond_reg, ratio_reg;

    logic signed [24:0] cx [3];
    logic [1:0]         sel_ax, sel_ix;
    logic signed [24:0] c_sel, prev_sel, first_sel, mul_in;
    logic signed [49:0] sq;
    logic [SSUM_W-1:0]  ssum_sel;
    logic signed [CSUM_W-1:0] csum_sel;
    logic [BSUM_W-1:0]  bsum_sel;
    logic [CSUM_W-1:0]  abs_s;
    logic [2:0]         pstep;
    logic [CNT_W-1:0]   target;
    logic [31:0]        len32, tgt32;
    logic               chain_end, out_free, emit_fire, bead_last, it_zero;

    logic [UW-1:0] add_a, add_b, r2, den, nm1;
    logic          add_sub;
    logic [UW:0]   add_sum;
    logic [UW-1:0] m_ua, m_ub, m_uq, d_ua, d_ub, d_uq, s_ua, s_ub, s_uq;
    logic [E_W-1:0] ee_full;
    logic [35:0]   ee_sat, gy_sat;
    logic [23:0]   bond_sat, ratio_sat;

    // Coordinates, axis selection and the shared squaring multiplier.
    always_comb
    begin
        cx[0] = {in_word_reg.x_pos[23], in_word_reg.x_pos};
        cx[1] = {in_word_reg.y_pos[23], in_word_reg.y_pos};
        cx[2] = {in_word_reg.z_pos[23], in_word_reg.z_pos};
        sel_ax = (state_reg == ST_BEAD) ? step_reg[2:1] : ax_reg;
        sel_ix = (sel_ax == AXIS_TOTAL) ? 2'd0 : sel_ax;
        c_sel     = cx[sel_ix];
        prev_sel  = {prev_reg[sel_ix][23], prev_reg[sel_ix]};
        first_sel = {first_reg[sel_ix][23], first_reg[sel_ix]};
        ssum_sel  = ssum_reg[sel_ix];
        csum_sel  = csum_reg[sel_ix];
        bsum_sel  = bsum_reg[sel_ix];
        abs_s     = csum_sel[CSUM_W-1] ? $unsigned(-csum_sel) : $unsigned(csum_sel);
        case (state_reg)
            ST_BEAD: mul_in = step_reg[0] ? (c_sel - prev_sel) : c_sel;
            ST_NN:   mul_in = $signed(25'(cnt_reg));
            default: mul_in = first_sel - prev_sel;
        endcase
        sq = mul_in * mul_in;
        pstep = step_reg - 3'd1;
    end

    // Target length, clamped to the supported range.
    always_comb
    begin
        len32 = 32'(cfg_len_reg);
        if (len32 < 32'd2)
        begin
            tgt32 = 32'd2;
        end
        else if (len32 > 32'(MAX_BEADS))
        begin
            tgt32 = 32'(MAX_BEADS);
        end
        else
        begin
            tgt32 = len32;
        end
        target = tgt32[CNT_W-1:0];
        chain_end = ({1'b0, cnt_reg} + (CNT_W + 1)'(1)) >= {1'b0, target};
    end

    // Shared adder and subtractor with its operand selection.
    always_comb
    begin
        r2  = {ua_reg[UW-2:0], ub_reg[UW-1]};
        den = UW'({nn_reg, 12'b0});
        nm1 = UW'(cnt_reg - CNT_W'(1));
        case (state_reg) inside
            ST_GMUL1, ST_GMUL2, ST_RMUL:
            begin
                add_a = ua_reg; add_b = ub_reg; add_sub = 1'b0;
            end
            ST_GDIV, ST_BDIV, ST_RDIV:
            begin
                add_a = r2; add_b = ud_reg; add_sub = 1'b1;
            end
            ST_SQRT:
            begin
                add_a = ua_reg; add_b = ub_reg | uq_reg; add_sub = 1'b1;
            end
            ST_GSUB:
            begin
                add_a = t1_reg; add_b = ua_reg; add_sub = 1'b1;
            end
            default:
            begin
                add_a = ua_reg; add_b = ub_reg; add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
                  + (UW + 1)'(add_sub);
        m_ua = uq_reg[0] ? add_sum[UW-1:0] : ua_reg;
        m_ub = ub_reg << 1;
        m_uq = uq_reg >> 1;
        d_ua = add_sum[UW] ? add_sum[UW-1:0] : r2;
        d_ub = ub_reg << 1;
        d_uq = {uq_reg[UW-2:0], add_sum[UW]};
        s_ua = add_sum[UW] ? add_sum[UW-1:0] : ua_reg;
        s_ub = add_sum[UW] ? ((ub_reg >> 1) | uq_reg) : (ub_reg >> 1);
        s_uq = uq_reg >> 2;
        it_zero = (it_reg == '0);
    end

    // Saturated result fields.
    always_comb
    begin
        gy_sat    = (|uq_reg[UW-1:36]) ? MAX36 : uq_reg[35:0];
        bond_sat  = (|ub_reg[UW-1:24]) ? MAX24 : ub_reg[23:0];
        ratio_sat = (|uq_reg[UW-1:24]) ? MAX24 : uq_reg[23:0];
        ee_full   = (ax_reg == AXIS_TOTAL) ? etot_reg : e_reg;
        ee_sat    = (|ee_full[E_W-1:48]) ? MAX36 : ee_full[47:12];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_BEAD;
            ST_BEAD:  if (step_reg == STEP_LAST) state_next = chain_end ? ST_NN : ST_IDLE;
            ST_NN:    state_next = ST_NNSET;
            ST_NNSET: state_next = ST_GSET;
            ST_GSET:  state_next = (ax_reg == AXIS_TOTAL) ? ST_GDIV : ST_GMUL1;
            ST_GMUL1: if (it_zero) state_next = ST_GMUL2;
            ST_GMUL2: if (it_zero) state_next = ST_GSUB;
            ST_GSUB:  state_next = ST_GDIV;
            ST_GDIV:  if (it_zero) state_next = ST_BDIV;
            ST_BDIV:  if (it_zero) state_next = ST_SQRT;
            ST_SQRT:  if (it_zero) state_next = (ax_reg == AXIS_TOTAL) ? ST_RMUL : ST_EMIT;
            ST_RMUL:  if (it_zero) state_next = (gtot_reg == '0) ? ST_EMIT : ST_RDIV;
            ST_RDIV:  if (it_zero) state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = (ax_reg == AXIS_TOTAL) ? ST_IDLE : ST_GSET;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE) && !in_valid;
        out_free  = !out_valid_reg || out_ready;
        emit_fire = (state_reg == ST_EMIT) && out_free;
        bead_last = (state_reg == ST_BEAD) && (step_reg == STEP_LAST);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control state and chain accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ax_reg        <= '0;
            cnt_reg       <= '0;
            cfg_len_reg   <= LEN_RESET;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                csum_reg[a] <= '0;
                ssum_reg[a] <= '0;
                bsum_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_len_reg <= cfg_data;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_BEAD)
            begin
                step_reg <= step_reg + 3'd1;
            end
            for (int a = 0; a < 3; a++)
            begin
                if ((state_reg == ST_BEAD) && (step_reg != '0) && (pstep[2:1] == 2'(a)))
                begin
                    if (!pstep[0])
                    begin
                        ssum_reg[a] <= ssum_reg[a] + SSUM_W'(prod_reg);
                    end
                    else if (cnt_reg != '0)
                    begin
                        bsum_reg[a] <= bsum_reg[a] + BSUM_W'(prod_reg);
                    end
                end
                if (bead_last)
                begin
                    csum_reg[a] <= csum_reg[a] + CSUM_W'(cx[a]);
                end
                if (emit_fire && (ax_reg == AXIS_TOTAL))
                begin
                    csum_reg[a] <= '0;
                    ssum_reg[a] <= '0;
                    bsum_reg[a] <= '0;
                end
            end
            if (bead_last)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_NNSET)
            begin
                ax_reg <= '0;
            end
            if (emit_fire)
            begin
                if (ax_reg == AXIS_TOTAL)
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    ax_reg <= ax_reg + 2'd1;
                end
            end
        end
    end

    // Datapath of the shared unit and the result words.
    always_ff @(posedge clk)
    begin
        prod_reg <= sq;
        if (bead_last)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prev_reg[a] <= cx[a][23:0];
                if (cnt_reg == '0)
                begin
                    first_reg[a] <= cx[a][23:0];
                end
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_word_reg <= in_data;
                end
            end
            ST_NNSET:
            begin
                nn_reg   <= prod_reg[NN_W-1:0];
                gtot_reg <= '0;
                etot_reg <= '0;
                btot_reg <= '0;
            end
            ST_GSET:
            begin
                ua_reg <= '0;
                if (ax_reg != AXIS_TOTAL)
                begin
                    ub_reg <= UW'(ssum_sel);
                    uq_reg <= UW'(cnt_reg);
                    it_reg <= IT_W'(CNT_W);
                end
                else
                begin
                    ub_reg <= gtot_reg;
                    uq_reg <= '0;
                    ud_reg <= den;
                    it_reg <= IT_W'(UW);
                end
            end
            ST_GMUL1:
            begin
                if (!it_zero)
                begin
                    ua_reg <= m_ua; ub_reg <= m_ub; uq_reg <= m_uq;
                    it_reg <= it_reg - IT_W'(1);
                end
                else
                begin
                    t1_reg <= ua_reg;
                    ua_reg <= '0;
                    ub_reg <= UW'(abs_s);
                    uq_reg <= UW'(abs_s);
                    it_reg <= IT_W'(CSUM_W);
                end
            end
            ST_GMUL2, ST_RMUL:
            begin
                if (!it_zero)
                begin
                    ua_reg <= m_ua; ub_reg <= m_ub; uq_reg <= m_uq;
                    it_reg <= it_reg - IT_W'(1);
                end
                else if (state_reg == ST_RMUL)
                begin
                    ub_reg <= ua_reg;
                    ua_reg <= '0;
                    uq_reg <= '0;
                    ud_reg <= gtot_reg;
                    it_reg <= IT_W'(UW);
                    ratio_reg <= MAX24;
                end
            end
            ST_GSUB:
            begin
                gtot_reg <= gtot_reg + add_sum[UW-1:0];
                etot_reg <= etot_reg + prod_reg;
                e_reg    <= prod_reg;
                btot_reg <= btot_reg + BTOT_W'(bsum_sel);
                ua_reg   <= '0;
                ub_reg   <= add_sum[UW-1:0];
                uq_reg   <= '0;
                ud_reg   <= den;
                it_reg   <= IT_W'(UW);
            end
            ST_GDIV, ST_BDIV, ST_RDIV:
            begin
                if (!it_zero)
                begin
                    ua_reg <= d_ua; ub_reg <= d_ub; uq_reg <= d_uq;
                    it_reg <= it_reg - IT_W'(1);
                end
                else if (state_reg == ST_GDIV)
                begin
                    gy_reg <= gy_sat;
                    ua_reg <= '0;
                    ub_reg <= (ax_reg == AXIS_TOTAL) ? UW'(btot_reg) : UW'(bsum_sel);
                    uq_reg <= '0;
                    ud_reg <= nm1;
                    it_reg <= IT_W'(UW);
                end
                else if (state_reg == ST_BDIV)
                begin
                    ua_reg <= UW'(uq_reg[SQRT_W-1:0]);
                    ub_reg <= '0;
                    uq_reg <= UW'(1) << (SQRT_W - 2);
                    it_reg <= IT_W'(SQRT_STEPS);
                end
                else
                begin
                    ratio_reg <= ratio_sat;
                end
            end
            ST_SQRT:
            begin
                if (!it_zero)
                begin
                    ua_reg <= s_ua; ub_reg <= s_ub; uq_reg <= s_uq;
                    it_reg <= it_reg - IT_W'(1);
                end
                else
                begin
                    bond_reg <= bond_sat;
                    if (ax_reg == AXIS_TOTAL)
                    begin
                        ua_reg <= '0;
                        ub_reg <= UW'({etot_reg, 16'b0});
                        uq_reg <= UW'(nn_reg);
                        it_reg <= IT_W'(NN_W);
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_data_reg.axis          <= ax_reg;
                    out_data_reg.bond_rms      <= bond_reg;
                    out_data_reg.gyration_sq   <= gy_reg;
                    out_data_reg.end_to_end_sq <= ee_sat;
                    out_data_reg.shape_ratio   <= (ax_reg == AXIS_TOTAL) ? ratio_reg : '0;
                    out_data_reg.last          <= (ax_reg == AXIS_TOTAL);
                end
            end
            default:
            begin
            end
        endcase
    end

    `PCSS_ASSERT_IMP(a_last_on_total, out_valid_reg,
        out_data_reg.last == (out_data_reg.axis == AXIS_TOTAL), "last flag off the total word")
    `PCSS_ASSERT_IMP(a_ratio_only_total, out_valid_reg && !out_data_reg.last,
        out_data_reg.shape_ratio == '0, "shape ratio set on an axis word")
    `PCSS_ASSERT_NXT(a_chain_clears, emit_fire && (ax_reg == AXIS_TOTAL),
        (state_reg == ST_IDLE) && (cnt_reg == '0), "chain state not cleared after total")
    `PCSS_ASSERT_IMP(a_word_from_emit, $rose(out_valid_reg),
        $past(state_reg) == ST_EMIT, "result word raised outside hand-over")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polymer chain shape statistics: testbench
// Streams bead coordinates through the block under several chain lengths and
// checks every result word against a bit-accurate predictor of the per-axis
// and total shape statistics or set totals, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import pcss_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned BEAD_SETTLE = 20;

    typedef struct {
        bead_t  bead;
        bit     typed;
        shape_t total;
    } bead_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    bead_t            in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    shape_t           out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;

    shape_t shape_q[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned beads_sent = 0;
    int unsigned words_checked = 0;
    int unsigned chains_done = 0;
    int unsigned stall_left = 0;
    bit quiet = 1'b0;
    bit long_hold_done = 1'b0;

    int unsigned      chain_len;
    int unsigned      bead_total;
    logic signed [63:0] first_pos[3];
    logic signed [63:0] prev_pos[3];
    logic signed [63:0] coord_sum[3];
    logic [63:0]        sq_sum[3];
    logic [63:0]        step_sq_sum[3];

    polymer_chain_shape_stats u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] bond_rms_of(logic [127:0] b, logic [127:0] n);
        logic [63:0] r;
        r = root_floor(64'(b / (n - 1)));
        return (r > MAX24) ? MAX24 : r[23:0];
    endfunction

    function automatic logic [35:0] sat36(logic [127:0] v);
        return (v > MAX36) ? MAX36 : v[35:0];
    endfunction

    function automatic logic signed [23:0] coord_of(bead_t b, int a);
        return (a == 0) ? b.x_pos : (a == 1) ? b.y_pos : b.z_pos;
    endfunction

    task automatic predict_chain_stats(input bead_t b);
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic [127:0] n, nn, den, g, gtot, etot, e, sa, q;
        logic [63:0] btot;
        int unsigned target;
        shape_t r;
        target = chain_len;
        if (target < 2) target = 2;
        if (target > MAX_BEADS_DEF) target = MAX_BEADS_DEF;
        for (int a = 0; a < 3; a++)
        begin
            c = coord_of(b, a);
            if (bead_total == 0)
                first_pos[a] = c;
            else
            begin
                d = c - prev_pos[a];
                step_sq_sum[a] = step_sq_sum[a] + 64'(d * d);
            end
            prev_pos[a] = c;
            coord_sum[a] = coord_sum[a] + c;
            sq_sum[a] = sq_sum[a] + 64'(c * c);
        end
        bead_total++;
        if (bead_total < target)
            return;
        n = bead_total;
        nn = n * n;
        den = nn << 12;
        gtot = 0;
        etot = 0;
        btot = 0;
        for (int a = 0; a < 3; a++)
        begin
            sa = (coord_sum[a] < 0) ? 128'(-coord_sum[a]) : 128'(coord_sum[a]);
            g = n * 128'(sq_sum[a]) - sa * sa;
            d = first_pos[a] - prev_pos[a];
            e = 128'(64'(d * d));
            gtot = gtot + g;
            etot = etot + e;
            btot = btot + step_sq_sum[a];
            r.axis = 2'(a);
            r.bond_rms = bond_rms_of(128'(step_sq_sum[a]), n);
            r.gyration_sq = sat36(g / den);
            r.end_to_end_sq = sat36(e >> 12);
            r.shape_ratio = '0;
            r.last = 1'b0;
            shape_q.push_back(r);
        end
        if (gtot == 0)
            r.shape_ratio = MAX24;
        else
        begin
            q = (etot * (nn << 16)) / gtot;
            r.shape_ratio = (q > MAX24) ? MAX24 : q[23:0];
        end
        r.axis = AXIS_TOTAL;
        r.bond_rms = bond_rms_of(128'(btot), n);
        r.gyration_sq = sat36(gtot / den);
        r.end_to_end_sq = sat36(etot >> 12);
        r.last = 1'b1;
        shape_q.push_back(r);
        chains_done++;
        bead_total = 0;
        for (int a = 0; a < 3; a++)
        begin
            coord_sum[a] = 0;
            sq_sum[a] = 0;
            step_sq_sum[a] = 0;
        end
    endtask

    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic send_bead(input bead_t b);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
        beads_sent++;
        predict_chain_stats(b);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (shape_q.size() == 0);
        repeat (BEAD_SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        chain_len = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] walk_coord(logic signed [23:0] p);
        logic signed [23:0] step;
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'sh800000;
            2: return 24'sh7FFFFF;
            default:
            begin
                step = 24'($signed($urandom_range(0, 16383)) - 8192);
                return p + step;
            end
        endcase
    endfunction

    task automatic send_walk(input int unsigned count);
        bead_t b;
        b.x_pos = 24'($urandom);
        b.y_pos = 24'($urandom);
        b.z_pos = 24'($urandom);
        for (int i = 0; i < count; i++)
        begin
            b.x_pos = walk_coord(b.x_pos);
            b.y_pos = walk_coord(b.y_pos);
            b.z_pos = walk_coord(b.z_pos);
            send_bead(b);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (shape_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected: %p", $time, out_data);
                errors++;
            end
            else
            begin
                if (shape_q[0] !== out_data)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, shape_q[0], out_data);
                    errors++;
                end
                void'(shape_q.pop_front());
            end
            words_checked++;
            if (!long_hold_done && words_checked == 41)
            begin
                long_hold_done = 1'b1;
                stall_left <= 2500;
            end
            else
                stall_left <= draw_gap();
        end
    end

    bead_row_t rows[$];
    const shape_t flat_total = '{AXIS_TOTAL, 24'd0, 36'd0, 36'd0, MAX24, 1'b1};

    initial
    begin
        chain_len = LEN_RESET;
        bead_total = 0;
        for (int a = 0; a < 3; a++)
        begin
            first_pos[a] = 0;
            prev_pos[a] = 0;
            coord_sum[a] = 0;
            sq_sum[a] = 0;
            step_sq_sum[a] = 0;
        end
        rows = '{
            '{'{24'sd0, 24'sd0, 24'sd0}, 1'b0, flat_total},
            '{'{24'sd0, 24'sd0, 24'sd0}, 1'b1, flat_total},
            '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b0, flat_total},
            '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b1, flat_total},
            '{'{24'sh800000, 24'sh800000, 24'sh800000}, 1'b0, flat_total},
            '{'{24'sh800000, 24'sh800000, 24'sh800000}, 1'b1, flat_total},
            '{'{24'sh800000, 24'sh800000, 24'sh800000}, 1'b0, flat_total},
            '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b0, flat_total},
            '{'{24'sh7FFFFF, 24'sh800000, 24'sd0}, 1'b0, flat_total},
            '{'{24'sh800000, 24'sh7FFFFF, -24'sd1}, 1'b0, flat_total},
            '{'{24'sd1, -24'sd1, 24'sh555555}, 1'b0, flat_total},
            '{'{-24'sd1, 24'sd1, 24'shAAAAAA}, 1'b0, flat_total},
            '{'{24'sd4096, 24'sd0, 24'sd0}, 1'b0, flat_total},
            '{'{24'sd0, 24'sd4096, 24'sd0}, 1'b0, flat_total}
        };
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_bead(rows[i].bead);
            if (rows[i].typed)
                shape_q[shape_q.size() - 1] = rows[i].total;
        end

        write_length(11'd0);
        send_walk(12);
        quiet = 1'b1;
        write_length(11'd1);
        send_walk(10);
        quiet = 1'b0;
        write_length(11'd2047);
        send_walk(15);
        write_length(11'd4);
        send_walk(21);
        write_length(11'd1024);
        quiet = 1'b1;
        send_walk(30);
        quiet = 1'b0;
        write_length(11'd3);
        send_walk(60);
        write_length(11'd7);
        send_walk(70);
        quiet = 1'b1;
        write_length(11'd5);
        send_walk(50);
        quiet = 1'b0;
        write_length(11'd2);
        send_walk(40);
        write_length(11'd16);
        send_walk(64);
        for (int p = 0; p < 2; p++)
        begin
            write_length(11'($urandom_range(2, 12)));
            send_walk(25);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (shape_q.size() == 0);
        repeat (BEAD_SETTLE) @(posedge clk);

        $display("Sent %0d beads; checked %0d result words over %0d chains.",
                 beads_sent, words_checked, chains_done);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
